/* rtl/matrix_4x4_multiply_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix multiply core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_4X4_MULTIPLY_CORE_ASSERT_SVH
`define MATRIX_4X4_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication
`define MM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// Types and constants shared by the 4x4 fixed-point matrix multiply core.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int ROW_W     = 2;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = PROD_W + $clog2(DIM);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [ROW_W-1:0]  row_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_t;

  // lane pipeline enables
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctrl_t;

  // output stage control
  typedef struct packed {
    logic adv;
    logic vld;
  } merge_ctrl_t;

endpackage

/* rtl/mm_if.sv */
// ----------------------------------------------------------------------------
// mm_in_if / mm_out_if
// Valid/ready channels for row commands and result rows.
// ----------------------------------------------------------------------------
interface mm_in_if;
  logic          valid;
  logic          ready;
  logic          cmd;
  mm_pkg::row_t  row_index;
  mm_pkg::elem_t elem_0;
  mm_pkg::elem_t elem_1;
  mm_pkg::elem_t elem_2;
  mm_pkg::elem_t elem_3;

  modport source (output valid, cmd, row_index, elem_0, elem_1, elem_2, elem_3,
                  input ready);
  modport sink   (input valid, cmd, row_index, elem_0, elem_1, elem_2, elem_3,
                  output ready);
endinterface

interface mm_out_if;
  logic          valid;
  logic          ready;
  mm_pkg::row_t  out_row;
  mm_pkg::elem_t res_0;
  mm_pkg::elem_t res_1;
  mm_pkg::elem_t res_2;
  mm_pkg::elem_t res_3;

  modport source (output valid, out_row, res_0, res_1, res_2, res_3,
                  input ready);
  modport sink   (input valid, out_row, res_0, res_1, res_2, res_3,
                  output ready);
endinterface

/* rtl/matrix_4x4_multiply_core.sv */
// ----------------------------------------------------------------------------
// matrix_4x4_multiply_core
// Fixed-point Q16.16 4x4 matrix product, one left row per transaction.
//
// in_ch carries a command, a row number and four Q16.16 elements. A load
// transaction writes that row of the right matrix into the operand store;
// it produces no result. A multiply transaction sends the left row through
// four column lanes and returns the product row on out_ch, each column
// shifted right by 16 and saturated to 32 bits, with the row number echoed.
// Rows of the right matrix must be loaded before a multiply uses them.
// A load takes effect for the very next transaction.
// The edge that accepts a multiply transaction loads the product register;
// the row then moves to the sum register and on to the output register.
// Throughput: one transaction per cycle while out_ch does not stall, set
// by the three-stage pipeline of product, sum and output registers; each
// lane holds four 32x32 multipliers.
// When out_ch stalls, the pipeline keeps filling its empty stages and
// in_ch.ready drops only once every stage holds a row.
// Reset (rst_n low, synchronous) empties the pipeline; the operand store
// is not cleared.
// ----------------------------------------------------------------------------
`include "matrix_4x4_multiply_core_assert.svh"

module matrix_4x4_multiply_core (
  input  logic     clk,
  input  logic     rst_n,
  mm_in_if.sink    in_ch,
  mm_out_if.source out_ch
);

  mm_pkg::elem_t store_r [mm_pkg::DIM][mm_pkg::DIM];
  mm_pkg::elem_t row_in  [mm_pkg::DIM];
  mm_pkg::elem_t col     [mm_pkg::DIM][mm_pkg::DIM];
  mm_pkg::sum_t  sums    [mm_pkg::DIM];

  logic         v1_r, v2_r;
  mm_pkg::row_t row1_r, row2_r;
  logic         adv1, adv2, adv3;
  logic         in_acc, is_mul;

  mm_pkg::lane_ctrl_t  lane_ctrl;
  mm_pkg::merge_ctrl_t merge_ctrl;

  assign row_in[0] = in_ch.elem_0;
  assign row_in[1] = in_ch.elem_1;
  assign row_in[2] = in_ch.elem_2;
  assign row_in[3] = in_ch.elem_3;

  // a stage advances when it is empty or the next one advances
  assign adv3 = !out_ch.valid || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_ch.ready = adv1;
  assign in_acc      = in_ch.valid && adv1;
  assign is_mul      = (in_ch.cmd == mm_pkg::CMD_MUL);

  always_ff @(posedge clk) begin
    if (in_acc && !is_mul) begin
      for (int j = 0; j < mm_pkg::DIM; j++) begin
        store_r[in_ch.row_index][j] <= row_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_ch.valid && is_mul;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_mul) begin
      row1_r <= in_ch.row_index;
    end
    if (adv2 && v1_r) begin
      row2_r <= row1_r;
    end
  end

  assign lane_ctrl.en_mul = in_acc && is_mul;
  assign lane_ctrl.en_sum = adv2 && v1_r;
  assign merge_ctrl.adv   = adv3;
  assign merge_ctrl.vld   = v2_r;

  for (genvar j = 0; j < mm_pkg::DIM; j++) begin : g_lane
    for (genvar k = 0; k < mm_pkg::DIM; k++) begin : g_col
      assign col[j][k] = store_r[k][j];
    end

    mm_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .a    (row_in),
      .b    (col[j]),
      .sum  (sums[j])
    );
  end

  mm_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (merge_ctrl),
    .row    (row2_r),
    .sums   (sums),
    .out_ch (out_ch)
  );

  `MM_ASSERT_IMP(a_stall_full, !in_ch.ready,
                 v1_r && v2_r && out_ch.valid && !out_ch.ready,
                 "input blocked while a pipeline stage is empty")
  `MM_ASSERT_NXT(a_load_silent, in_ch.valid && in_ch.ready && !is_mul, !v1_r,
                 "load transaction entered the multiply pipeline")
  `MM_ASSERT_NXT(a_mul_enter, in_ch.valid && in_ch.ready && is_mul,
                 v1_r && (row1_r == $past(in_ch.row_index)),
                 "multiply transaction lost at pipeline entry")
  `MM_ASSERT_NXT(a_sum_to_out, v2_r && !out_ch.valid, out_ch.valid,
                 "summed row did not reach the output register")

endmodule

/* rtl/mm_lane.sv */
// ----------------------------------------------------------------------------
// mm_lane
// One result column: products of the left row with a stored column, then sum.
// ----------------------------------------------------------------------------
module mm_lane (
  input  logic               clk,
  input  mm_pkg::lane_ctrl_t ctrl,
  input  mm_pkg::elem_t      a [mm_pkg::DIM],
  input  mm_pkg::elem_t      b [mm_pkg::DIM],
  output mm_pkg::sum_t       sum
);

  mm_pkg::prod_t prod_r   [mm_pkg::DIM];
  mm_pkg::prod_t prod_nxt [mm_pkg::DIM];
  mm_pkg::sum_t  sum_r;
  mm_pkg::sum_t  sum_nxt;

  // 32x32 signed products; sign-extend both operands to the product width
  always_comb begin
    for (int k = 0; k < mm_pkg::DIM; k++) begin
      prod_nxt[k] = mm_pkg::prod_t'(a[k]) * mm_pkg::prod_t'(b[k]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < mm_pkg::DIM; k++) begin
      sum_nxt = sum_nxt + mm_pkg::sum_t'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.en_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

/* rtl/mm_merge.sv */
// ----------------------------------------------------------------------------
// mm_merge
// Gathers the lane sums into one result row: shift, saturate, output register.
// ----------------------------------------------------------------------------
module mm_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  mm_pkg::merge_ctrl_t ctrl,
  input  mm_pkg::row_t        row,
  input  mm_pkg::sum_t        sums [mm_pkg::DIM],
  mm_out_if.source            out_ch
);

  localparam int HI_W = mm_pkg::SUM_W - mm_pkg::ELEM_W + 1;

  function automatic mm_pkg::elem_t shift_sat(input mm_pkg::sum_t s);
    mm_pkg::sum_t    sh;
    logic [HI_W-1:0] hi;
    sh = s >>> mm_pkg::FRAC_BITS;
    hi = sh[mm_pkg::SUM_W-1:mm_pkg::ELEM_W-1];
    if ((&hi) || !(|hi)) begin
      shift_sat = sh[mm_pkg::ELEM_W-1:0];
    end else if (sh[mm_pkg::SUM_W-1]) begin
      shift_sat = {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}};
    end else begin
      shift_sat = {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};
    end
  endfunction

  logic          out_valid_r;
  mm_pkg::row_t  out_row_r;
  mm_pkg::elem_t res_r   [mm_pkg::DIM];
  mm_pkg::elem_t res_nxt [mm_pkg::DIM];

  always_comb begin
    for (int j = 0; j < mm_pkg::DIM; j++) begin
      res_nxt[j] = shift_sat(sums[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.adv) begin
      out_valid_r <= ctrl.vld;
    end
  end

  // hold the row while the receiver stalls
  always_ff @(posedge clk) begin
    if (ctrl.adv && ctrl.vld) begin
      out_row_r <= row;
      res_r     <= res_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.res_0   = res_r[0];
  assign out_ch.res_1   = res_r[1];
  assign out_ch.res_2   = res_r[2];
  assign out_ch.res_3   = res_r[3];

endmodule
